[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/chacha_pkg.sv]
// Shared types, constants and functions of the ChaCha20 stream block.
package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
  localparam int unsigned MID_DEPTH         = 4;
  localparam int unsigned OUT_DEPTH         = 2;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
  localparam logic [2:0] LAST_WORD_POS   = 3'd7;

  typedef enum logic [2:0] {
    CFG_KEY0      = 3'd0,
    CFG_KEY1      = 3'd1,
    CFG_KEY2      = 3'd2,
    CFG_KEY3      = 3'd3,
    CFG_NONCE_LO  = 3'd4,
    CFG_NONCE_HI  = 3'd5,
    CFG_INIT_CTR  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_lo;
    logic [31:0]      nonce_hi;
  } key_cfg_t;

  // One request queued between front and back.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic        need_blk;
    logic [2:0]  pos;
    logic [31:0] ctr;
  } item_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_st_t;

  typedef struct packed {
    logic proc;
    logic need_blk;
    logic blk_ok;
    logic start;
  } back_st_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned amt);
    rotl = (v << amt) | (v >> (32 - amt));
  endfunction

  function automatic qr_t qround(input logic [31:0] a_in, input logic [31:0] b_in,
                                 input logic [31:0] c_in, input logic [31:0] d_in);
    logic [31:0] a, b, c, d;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qround = '{a: a, b: b, c: c, d: d};
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < cnt) begin
        m[8*b +: 8] = 8'hff;
      end
    end
    byte_mask = m;
  endfunction

endpackage

[src/chacha20_stream_xor.sv]
// ChaCha20 keystream XOR over 64-bit little-endian words. Words enter a short queue at
// up to one per cycle while it is not full; the back end takes them in order. The first
// word of each 64-byte stretch waits while the keystream engine builds a block: a start
// step, the rounds (2 * DOUBLE_ROUNDS, 20 by default) and a feed-forward step; the other
// seven words of the stretch then pass without waiting for the engine. Sustained rate is
// set by the single round unit, which builds a block only once its first word is at the
// head of the queue. Results leave through a two-entry output queue. Config writes are
// always taken and must be made only while no request is in flight.
`include "assert_macros.svh"

module chacha20_stream_xor #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] data_in_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] data_out_o,
  output logic [3:0]  out_byte_count_o,
  output logic        last_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import chacha_pkg::*;

  key_cfg_t          key_cfg_q;
  logic [31:0]       init_ctr_q;
  item_t             in_item, head;
  result_t           res, out_res;
  logic              in_accept, head_valid, mid_empty, head_pop;
  logic              out_full, out_push;
  logic              core_start;
  logic [31:0]       core_ctr;
  core_st_t          core_st;
  back_st_t          back_st;
  logic [15:0][31:0] ks;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cfg_q  <= '0;
      init_ctr_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KEY0:     key_cfg_q.key[0]   <= cfg_data_i;
        CFG_KEY1:     key_cfg_q.key[1]   <= cfg_data_i;
        CFG_KEY2:     key_cfg_q.key[2]   <= cfg_data_i;
        CFG_KEY3:     key_cfg_q.key[3]   <= cfg_data_i;
        CFG_NONCE_LO: key_cfg_q.nonce_lo <= cfg_data_i;
        CFG_NONCE_HI: key_cfg_q.nonce_hi <= cfg_data_i[31:0];
        CFG_INIT_CTR: init_ctr_q         <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  chacha_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .data_i     (data_in_i),
    .cnt_i      (byte_count_i),
    .last_i     (last_in_i),
    .init_ctr_i (init_ctr_q),
    .item_o     (in_item)
  );

  chacha_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (in_item),
    .pop_i   (head_pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (mid_empty)
  );

  assign head_valid = !mid_empty;

  chacha_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .ctr_i   (core_ctr),
    .cfg_i   (key_cfg_q),
    .st_o    (core_st),
    .ks_o    (ks)
  );

  chacha_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_o        (res),
    .core_start_o (core_start),
    .core_ctr_o   (core_ctr),
    .core_st_i    (core_st),
    .ks_i         (ks),
    .st_o         (back_st)
  );

  chacha_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res),
    .pop_i   (pop),
    .rdata_o (out_res),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign data_out_o       = out_res.data;
  assign out_byte_count_o = out_res.cnt;
  assign last_out_o       = out_res.last;

  `ASSERT_IMPL(a_start_idle, back_st.start, !core_st.busy)
  `ASSERT_IMPL(a_blk_before_use, back_st.proc && back_st.need_blk, back_st.blk_ok)
  `ASSERT_NEXT(a_done_marks_ok, core_st.done, back_st.blk_ok)
  `ASSERT_IMPL(a_out_no_overflow, out_push, !out_full)
endmodule

[src/chacha_fifo.sv]
// Small flip-flop queue with registered storage and first-word read-out.
module chacha_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end
endmodule

[src/chacha_front.sv]
// Front end: tracks message position and block counter, tags each request.
module chacha_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [63:0]         data_i,
  input  logic [3:0]          cnt_i,
  input  logic                last_i,
  input  logic [31:0]         init_ctr_i,
  output chacha_pkg::item_t   item_o
);
  import chacha_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [31:0] ctr_q, ctr_d, ctr;
  logic        active_q, active_d;
  logic [3:0]  cnt;

  assign pos = active_q ? pos_q : '0;
  assign ctr = active_q ? ctr_q : init_ctr_i;
  assign cnt = (last_i && cnt_i != '0 && cnt_i <= FULL_WORD_BYTES) ? cnt_i : FULL_WORD_BYTES;

  assign item_o = '{data: data_i, cnt: cnt, last: last_i, need_blk: (pos == '0),
                    pos: pos, ctr: ctr};

  always_comb begin
    pos_d    = pos_q;
    ctr_d    = ctr_q;
    active_d = active_q;
    if (accept_i) begin
      if (last_i) begin
        active_d = 1'b0;
        pos_d    = '0;
        ctr_d    = ctr;
      end else if (pos == LAST_WORD_POS) begin
        active_d = 1'b1;
        pos_d    = '0;
        ctr_d    = ctr + 32'd1;
      end else begin
        active_d = 1'b1;
        pos_d    = pos + 3'd1;
        ctr_d    = ctr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ctr_q    <= '0;
      active_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      ctr_q    <= ctr_d;
      active_q <= active_d;
    end
  end
endmodule

[src/chacha_core.sv]
// Keystream engine: one column or diagonal round per cycle, then feed-forward.
module chacha_core #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            ctr_i,
  input  chacha_pkg::key_cfg_t   cfg_i,
  output chacha_pkg::core_st_t   st_o,
  output logic [15:0][31:0]      ks_o
);
  import chacha_pkg::*;

  localparam int unsigned ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RND_W  = $clog2(ROUNDS);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FEED  = 3'b100
  } core_state_e;

  core_state_e      state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [31:0]      ctr_q;
  logic [15:0][31:0] st_q, st_nxt, init_w, ks_q;
  qr_t              qc, qd;

  function automatic logic [15:0][31:0] init_words(input key_cfg_t c, input logic [31:0] ctr);
    logic [15:0][31:0] w;
    w[0]  = SIGMA0;
    w[1]  = SIGMA1;
    w[2]  = SIGMA2;
    w[3]  = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      w[4 + 2*k] = c.key[k][31:0];
      w[5 + 2*k] = c.key[k][63:32];
    end
    w[12] = ctr;
    w[13] = c.nonce_lo[31:0];
    w[14] = c.nonce_lo[63:32];
    w[15] = c.nonce_hi;
    init_words = w;
  endfunction

  assign init_w = init_words(cfg_i, state_q == C_IDLE ? ctr_i : ctr_q);

  always_comb begin
    st_nxt = st_q;
    for (int i = 0; i < 4; i++) begin
      qc = qround(st_q[i], st_q[4 + i], st_q[8 + i], st_q[12 + i]);
      qd = qround(st_q[i], st_q[4 + (i + 1) % 4], st_q[8 + (i + 2) % 4],
                  st_q[12 + (i + 3) % 4]);
      if (!rnd_q[0]) begin
        st_nxt[i]      = qc.a;
        st_nxt[4 + i]  = qc.b;
        st_nxt[8 + i]  = qc.c;
        st_nxt[12 + i] = qc.d;
      end else begin
        st_nxt[i]                  = qd.a;
        st_nxt[4 + (i + 1) % 4]    = qd.b;
        st_nxt[8 + (i + 2) % 4]    = qd.c;
        st_nxt[12 + (i + 3) % 4]   = qd.d;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          state_d = C_ROUND;
          rnd_d   = '0;
        end
      end
      C_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RND_W'(ROUNDS - 1)) begin
          state_d = C_FEED;
        end
      end
      C_FEED:  state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      st_q  <= init_w;
      ctr_q <= ctr_i;
    end else if (state_q == C_ROUND) begin
      st_q <= st_nxt;
    end
    if (state_q == C_FEED) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= st_q[i] + init_w[i];
      end
    end
  end

  assign st_o = '{busy: (state_q != C_IDLE), done: (state_q == C_FEED)};
  assign ks_o = ks_q;
endmodule

[src/chacha_back.sv]
// Back end: starts keystream blocks on demand and XORs queued words.
module chacha_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chacha_pkg::item_t     head_i,
  input  logic                  head_valid_i,
  output logic                  head_pop_o,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output chacha_pkg::result_t   out_o,
  output logic                  core_start_o,
  output logic [31:0]           core_ctr_o,
  input  chacha_pkg::core_st_t  core_st_i,
  input  logic [15:0][31:0]     ks_i,
  output chacha_pkg::back_st_t  st_o
);
  import chacha_pkg::*;

  typedef enum logic [1:0] {
    B_RUN  = 2'b01,
    B_WAIT = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  logic        blk_ok_q, blk_ok_d;
  logic        proc, start;
  logic [63:0] ks_pair;

  assign proc    = head_valid_i && !out_full_i && (!head_i.need_blk || blk_ok_q);
  assign start   = (state_q == B_RUN) && head_valid_i && head_i.need_blk && !blk_ok_q;
  assign ks_pair = {ks_i[{head_i.pos, 1'b1}], ks_i[{head_i.pos, 1'b0}]};

  assign head_pop_o   = proc;
  assign out_push_o   = proc;
  assign out_o        = '{data: (head_i.data ^ ks_pair) & byte_mask(head_i.cnt),
                          cnt: head_i.cnt, last: head_i.last};
  assign core_start_o = start;
  assign core_ctr_o   = head_i.ctr;
  assign st_o         = '{proc: proc, need_blk: head_i.need_blk, blk_ok: blk_ok_q,
                          start: start};

  always_comb begin
    state_d  = state_q;
    blk_ok_d = blk_ok_q;
    if (proc && head_i.need_blk) begin
      blk_ok_d = 1'b0;
    end
    case (state_q)
      B_RUN: begin
        if (start) begin
          state_d = B_WAIT;
        end
      end
      B_WAIT: begin
        if (core_st_i.done) begin
          state_d  = B_RUN;
          blk_ok_d = 1'b1;
        end
      end
      default: state_d = B_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_RUN;
      blk_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      blk_ok_q <= blk_ok_d;
    end
  end
endmodule
